/* sv/btbp_pkg.sv */
// Shared types, constants and helpers for the two-level branch predictor.
// Used by btbp_front, btbp_back and the top level; depends on nothing else.
`default_nettype none
package btbp_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned MAX_HISTORY = 8;
  localparam int unsigned MAX_TAG     = 30;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned ADDR_W      = IDX_W + MAX_HISTORY;
  localparam int unsigned DATA_W      = 104;

  localparam logic [2:0] REG_INDEX_BITS   = 3'd0;
  localparam logic [2:0] REG_HISTORY_BITS = 3'd1;
  localparam logic [2:0] REG_TAG_BITS     = 3'd2;
  localparam logic [2:0] REG_INIT_COUNTER = 3'd3;
  localparam logic [2:0] REG_GLOBAL_HIST  = 3'd4;
  localparam logic [2:0] REG_GLOBAL_CNT   = 3'd5;
  localparam logic [2:0] REG_SHARE_MODE   = 3'd6;

  localparam logic [1:0] SHARE_PC2  = 2'd1;
  localparam logic [1:0] SHARE_PC16 = 2'd2;

  localparam logic OP_UPDATE = 1'b1;

  // Effective configuration, already clamped to the supported ranges.
  typedef struct packed {
    logic [2:0] index_bits;
    logic [3:0] history_bits;
    logic [4:0] tag_bits;
    logic [1:0] init_counter;
    logic       global_history;
    logic       global_counters;
    logic [1:0] share_mode;
  } cfg_t;

  // One decoded word as it travels from the front to the back.
  typedef struct packed {
    logic                   op;
    logic [IDX_W-1:0]       idx;
    logic [MAX_TAG-1:0]     tag;
    logic [31:0]            fall;
    logic [MAX_HISTORY-1:0] share;
    logic [31:0]            rtarget;
    logic                   taken;
    logic                   pred;
  } item_t;

  typedef struct packed {
    logic fill_busy;
    logic pop;
  } back_stat_t;

  function automatic logic [2:0] clamp_index(input logic [2:0] v);
    return (v > 3'(IDX_W)) ? 3'(IDX_W) : v;
  endfunction

  function automatic logic [3:0] clamp_history(input logic [3:0] v);
    return (v > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : v;
  endfunction

  function automatic logic [4:0] clamp_tag(input logic [4:0] v);
    return (v > 5'(MAX_TAG)) ? 5'(MAX_TAG) : v;
  endfunction

endpackage
`default_nettype wire

/* sv/btbp_front.sv */
// Front part: decodes incoming words into index, tag and share value and
// holds them in a two-entry queue for the back part. Depends on btbp_pkg.
`default_nettype none
module btbp_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // op[0], pc[32:1], resolved_target[64:33], was_taken[65],
  // predicted_destination[97:66], zero fill above
  input  wire logic [btbp_pkg::DATA_W-1:0] s_tdata,
  input  wire btbp_pkg::cfg_t              cfg,
  input  wire btbp_pkg::back_stat_t        stat,
  output logic                             q_valid,
  output btbp_pkg::item_t                  q_item
);
  import btbp_pkg::*;

  logic [31:0]            pc;
  logic [31:0]            pdst;
  logic [IDX_W-1:0]       idx_mask;
  logic [MAX_TAG-1:0]     tag_mask;
  item_t                  dec;
  item_t                  q_mem [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;
  logic                   pop;

  assign pc   = s_tdata[32:1];
  assign pdst = s_tdata[97:66];

  always_comb begin
    idx_mask     = IDX_W'((6'd1 << cfg.index_bits) - 6'd1);
    tag_mask     = MAX_TAG'((31'd1 << cfg.tag_bits) - 31'd1);
    dec.op       = s_tdata[0];
    dec.idx      = pc[IDX_W+1:2] & idx_mask;
    dec.tag      = MAX_TAG'(pc >> (6'd2 + 6'(cfg.index_bits))) & tag_mask;
    dec.fall     = pc + 32'd4;
    dec.rtarget  = s_tdata[64:33];
    dec.taken    = s_tdata[65];
    dec.pred     = (pdst != dec.fall);
    case (cfg.share_mode)
      SHARE_PC2:  dec.share = pc[MAX_HISTORY+1:2];
      SHARE_PC16: dec.share = pc[MAX_HISTORY+15:16];
      default:    dec.share = '0;
    endcase
  end

  assign s_tready = (count != 2'd2) && !stat.fill_busy;
  assign push     = s_tvalid && s_tready;
  assign pop      = stat.pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= dec;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* sv/btbp_back.sv */
// Back part: buffer lookup, counter memory, row clear and refill sweeps,
// statistics and the output register. Depends on btbp_pkg.
`default_nettype none
module btbp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire btbp_pkg::cfg_t              cfg,
  input  wire logic                        fill_req,
  input  wire logic                        q_valid,
  input  wire btbp_pkg::item_t             q_item,
  output btbp_pkg::back_stat_t             stat,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // predict_taken[0], predict_target[32:1], branch_count[64:33],
  // flush_count[96:65], zero fill above
  output logic [btbp_pkg::DATA_W-1:0]      m_tdata
);
  import btbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_CLEAR, S_READ, S_WAIT, S_FILL
  } state_t;

  state_t                 state;
  item_t                  item;
  logic                   hit;
  logic                   fill_pend;
  logic [ADDR_W-1:0]      caddr;
  logic [1:0]             rd;
  logic [MAX_HISTORY-1:0] col;
  logic [ADDR_W-1:0]      fa;
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_TAG-1:0]     tags    [MAX_ENTRIES];
  logic [31:0]            targets [MAX_ENTRIES];
  logic [MAX_HISTORY-1:0] lhist   [MAX_ENTRIES];
  logic [MAX_HISTORY-1:0] ghist;
  logic [31:0]            bcnt;
  logic [31:0]            fcnt;
  logic [1:0]             cnt_ram [1 << ADDR_W];

  logic                   look_hit;
  logic [MAX_HISTORY-1:0] hmask;
  logic [MAX_HISTORY-1:0] hist_sel;
  logic [ADDR_W-1:0]      addr_calc;
  logic [1:0]             newc;
  logic [MAX_HISTORY-1:0] hist_next;
  logic                   out_free;
  logic [31:0]            bcnt_next;
  logic [31:0]            fcnt_next;
  logic                   p_taken;
  logic [31:0]            p_target;
  logic                   wen;
  logic [ADDR_W-1:0]      waddr;
  logic [1:0]             wdata;

  always_comb begin
    look_hit  = valid[item.idx] && (tags[item.idx] == item.tag);
    hmask     = MAX_HISTORY'((9'd1 << cfg.history_bits) - 9'd1);
    hist_sel  = cfg.global_history ? ghist : lhist[item.idx];
    addr_calc = {(cfg.global_counters ? IDX_W'(0) : item.idx),
                 (hist_sel ^ item.share) & hmask};
    hist_next = ((hist_sel << 1) | MAX_HISTORY'(item.taken)) & hmask;
    if (item.taken) newc = (rd == 2'd3) ? rd : rd + 2'd1;
    else            newc = (rd == 2'd0) ? rd : rd - 2'd1;
    out_free  = !m_tvalid || m_tready;
    bcnt_next = (item.op == OP_UPDATE) ? bcnt + 32'd1 : bcnt;
    fcnt_next = ((item.op == OP_UPDATE) && (item.pred != item.taken)) ? fcnt + 32'd1
                                                                       : fcnt;
    p_taken   = 1'b0;
    p_target  = 32'd0;
    if (item.op != OP_UPDATE) begin
      p_target = item.fall;
      if (hit && rd[1]) begin
        p_taken  = 1'b1;
        p_target = targets[item.idx];
      end
    end
    wen   = 1'b0;
    waddr = caddr;
    wdata = newc;
    case (state)
      S_FILL: begin
        wen   = 1'b1;
        waddr = fa;
        wdata = cfg.init_counter;
      end
      S_CLEAR: begin
        wen   = 1'b1;
        waddr = {item.idx, col};
        wdata = cfg.init_counter;
      end
      S_WAIT:  wen = (item.op == OP_UPDATE) && out_free;
      default: wen = 1'b0;
    endcase
  end

  assign stat.fill_busy = (state == S_FILL) || fill_pend;
  assign stat.pop       = (state == S_IDLE) && !fill_pend;

  always_ff @(posedge clk) begin
    if (wen) cnt_ram[waddr] <= wdata;
    if (state == S_READ) rd <= cnt_ram[addr_calc];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fa        <= '0;
      fill_pend <= 1'b0;
      valid     <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) lhist[i] <= '0;
      ghist     <= '0;
      bcnt      <= '0;
      fcnt      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (fill_req) begin
        fill_pend <= 1'b1;
        fa        <= '0;
      end
      case (state)
        S_IDLE: begin
          if (fill_pend) begin
            state     <= S_FILL;
            fill_pend <= fill_req;
          end else if (q_valid) begin
            item  <= q_item;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit   <= look_hit;
          state <= S_READ;
          if (item.op == OP_UPDATE && !look_hit) begin
            valid[item.idx] <= 1'b1;
            tags[item.idx]  <= item.tag;
            if (!cfg.global_history) lhist[item.idx] <= '0;
            if (!cfg.global_counters) begin
              col   <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          col <= col + MAX_HISTORY'(1);
          if (&col) state <= S_READ;
        end
        S_READ: begin
          caddr <= addr_calc;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, fcnt_next, bcnt_next, p_target, p_taken};
            bcnt     <= bcnt_next;
            fcnt     <= fcnt_next;
            if (item.op == OP_UPDATE) begin
              targets[item.idx] <= item.rtarget;
              if (cfg.global_history) ghist <= hist_next;
              else                    lhist[item.idx] <= hist_next;
            end
            state <= S_IDLE;
          end
        end
        S_FILL: begin
          if (!fill_req) begin
            fa <= fa + ADDR_W'(1);
            if (&fa) begin
              state     <= S_IDLE;
              fill_pend <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/btb_two_level_branch_predictor.sv */
// Direct-mapped branch target buffer with two-level direction prediction.
// Each word is a predict or an update and gives one result word. An update
// that allocates an entry with per-entry counter rows first clears that row,
// because the back part walks the 256 counters of that row through the
// single write port of the counter memory. After reset, and after every
// write of initial_counter, the block refills all 8192 counters, one per
// cycle unless another such write restarts the sweep, and takes no word
// during that sweep. A two-entry queue sits between decode and execution,
// and an output register lets the next word start while a result waits to
// be taken. Depends on btbp_pkg, btbp_front and btbp_back.
`default_nettype none
module btb_two_level_branch_predictor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // op[0], pc[32:1], resolved_target[64:33], was_taken[65],
  // predicted_destination[97:66], zero fill above
  input  wire logic [btbp_pkg::DATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // predict_taken[0], predict_target[32:1], branch_count[64:33],
  // flush_count[96:65], zero fill above
  output logic [btbp_pkg::DATA_W-1:0]      m_tdata,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_data
);
  import btbp_pkg::*;

  logic [2:0] index_bits;
  logic [3:0] history_bits;
  logic [4:0] tag_bits;
  logic [1:0] init_counter;
  logic       global_history;
  logic       global_counters;
  logic [1:0] share_mode;
  cfg_t       cfg;
  logic       cfg_wr;
  logic       fill_req;
  back_stat_t stat;
  logic       q_valid;
  item_t      q_item;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign fill_req  = cfg_wr && (cfg_index == REG_INIT_COUNTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits      <= 3'd0;
      history_bits    <= 4'd1;
      tag_bits        <= 5'd0;
      init_counter    <= 2'd1;
      global_history  <= 1'b0;
      global_counters <= 1'b0;
      share_mode      <= 2'd0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_INDEX_BITS:   index_bits      <= cfg_data[2:0];
        REG_HISTORY_BITS: history_bits    <= cfg_data[3:0];
        REG_TAG_BITS:     tag_bits        <= cfg_data[4:0];
        REG_INIT_COUNTER: init_counter    <= cfg_data[1:0];
        REG_GLOBAL_HIST:  global_history  <= cfg_data[0];
        REG_GLOBAL_CNT:   global_counters <= cfg_data[0];
        REG_SHARE_MODE:   share_mode      <= cfg_data[1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    cfg.index_bits      = clamp_index(index_bits);
    cfg.history_bits    = clamp_history(history_bits);
    cfg.tag_bits        = clamp_tag(tag_bits);
    cfg.init_counter    = init_counter;
    cfg.global_history  = global_history;
    cfg.global_counters = global_counters;
    cfg.share_mode      = share_mode;
  end

  btbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .stat     (stat),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  btbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fill_req (fill_req),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
